>>> rtl/sbps_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the step beep pattern sequencer.
// Holds the constant-divisor step tests used by the step logic. No dependencies.
package sbps_pkg;

	// Step counter width; end steps wrap at this width
	localparam int STEP_BITS = 16;
	localparam int DUR_BITS  = 16;
	localparam int CMP_BITS  = (STEP_BITS > DUR_BITS) ? STEP_BITS : DUR_BITS;

	// Configuration port
	localparam int ADDR_BITS = 3;
	localparam int DATA_BITS = 32;
	localparam logic [ADDR_BITS-3:0] REG_STD_DURATION = '0;

	// Commands
	typedef enum logic [1:0] {
		CMD_SIM   = 2'd0,
		CMD_IND   = 2'd1,
		CMD_RESET = 2'd2,
		CMD_UNDEF = 2'd3
	} cmd_t;

	// Pattern numbers on the pattern field
	localparam logic [2:0] PAT_IDLE     = 3'd0;
	localparam logic [2:0] PAT_SIM_HOLD = 3'd7;
	localparam logic [2:0] PAT_HOLD1    = 3'd1;
	localparam logic [2:0] PAT_HOLD2    = 3'd2;
	localparam logic [2:0] PAT_VOL_UP   = 3'd3;
	localparam logic [2:0] PAT_VOL_DN   = 3'd4;
	localparam logic [2:0] PAT_PER_A    = 3'd5;
	localparam logic [2:0] PAT_PER_B    = 3'd6;
	localparam logic [2:0] PAT_UNKNOWN  = 3'd7;

	// Pattern actions after decode
	typedef enum logic [2:0] {
		ACT_BURST   = 3'd0,
		ACT_HOLD1   = 3'd1,
		ACT_HOLD2   = 3'd2,
		ACT_VOL_UP  = 3'd3,
		ACT_VOL_DN  = 3'd4,
		ACT_PER_A   = 3'd5,
		ACT_PER_B   = 3'd6,
		ACT_UNKNOWN = 3'd7
	} act_t;

	// Pin positions, active low
	localparam int PIN_T0 = 0;
	localparam int PIN_T1 = 1;
	localparam int PIN_T2 = 2;
	localparam int PIN_VD = 3;
	localparam int PIN_VU = 4;
	localparam logic [4:0] PINS_RELEASED  = 5'h1F;
	localparam logic [2:0] TRACKS_RELEASED = 3'b111;

	// Pattern codes
	localparam logic [3:0] CODE_IDLE     = 4'd0;
	localparam logic [3:0] CODE_IND_BASE = 4'd7;
	localparam logic [3:0] CODE_NONE     = 4'd15;

	// Durations
	localparam logic [DUR_BITS-1:0] DUR_STD_RESET = 16'd3000;
	localparam logic [DUR_BITS-1:0] DUR_HOLD1     = 16'd25000;
	localparam logic [DUR_BITS-1:0] DUR_HOLD2     = 16'd23500;
	localparam logic [DUR_BITS-1:0] DUR_VOLUME    = 16'd1000;
	localparam logic [DUR_BITS-1:0] DUR_PER_A     = 16'd1175;
	localparam logic [DUR_BITS-1:0] DUR_PER_B     = 16'd1210;

	// Pulse lengths and counts
	localparam logic [STEP_BITS-1:0] BEEP_LEN  = STEP_BITS'(35);
	localparam logic [STEP_BITS-1:0] VOL_LEN   = STEP_BITS'(50);
	localparam logic [STEP_BITS-1:0] PER_LEN_A = STEP_BITS'(175);
	localparam logic [STEP_BITS-1:0] PER_LEN_B = STEP_BITS'(210);
	localparam logic [3:0] VOL_MAX     = 4'd10;
	localparam logic [3:0] BURST_IDLE  = 4'd3;
	localparam logic [3:0] BURST_VOL   = 4'd10;

	// Reciprocals: floor(s*M >> K) equals floor(s/d) for every step value
	localparam int K100 = STEP_BITS + 7;
	localparam longint unsigned M100_L = ((64'd1 << K100) + 64'd99) / 64'd100;
	localparam logic [K100-7:0] M100 = M100_L[K100-7:0];
	localparam int K500 = STEP_BITS + 9;
	localparam longint unsigned M500_L = ((64'd1 << K500) + 64'd499) / 64'd500;
	localparam logic [K500-9:0] M500 = M500_L[K500-9:0];

	typedef struct packed {
		logic [1:0]           cmd;
		logic [2:0]           pattern;
		logic [STEP_BITS-1:0] step;
	} item_t;

	typedef struct packed {
		logic [4:0] pins;
		logic       done;
	} res_t;

	function automatic logic [STEP_BITS-7:0] quot100(input logic [STEP_BITS-1:0] s);
		logic [STEP_BITS+K100-7:0] p;
		p = {{(K100-6){1'b0}}, s} * {{STEP_BITS{1'b0}}, M100};
		return p[STEP_BITS+K100-7:K100];
	endfunction

	function automatic logic [STEP_BITS-9:0] quot500(input logic [STEP_BITS-1:0] s);
		logic [STEP_BITS+K500-9:0] p;
		p = {{(K500-8){1'b0}}, s} * {{STEP_BITS{1'b0}}, M500};
		return p[STEP_BITS+K500-9:K500];
	endfunction

	// A multiple of d is where the quotient steps up from the value below
	function automatic logic is_mult100(input logic [STEP_BITS-1:0] s);
		return (s == '0) || (quot100(s) != quot100(s - STEP_BITS'(1)));
	endfunction

	function automatic logic is_mult500(input logic [STEP_BITS-1:0] s);
		return (s == '0) || (quot500(s) != quot500(s - STEP_BITS'(1)));
	endfunction

endpackage

>>> rtl/sbps_cfg.sv
`timescale 1ns / 1ps
// APB register file: the standard duration register.
// Depends on sbps_pkg.
module sbps_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sbps_pkg::ADDR_BITS-1:0]   paddr,
	input  logic [sbps_pkg::DATA_BITS-1:0]   pwdata,
	output logic [sbps_pkg::DATA_BITS-1:0]   prdata,
	output logic                             pready,
	output logic [sbps_pkg::DUR_BITS-1:0]    std_dur
);

	logic [sbps_pkg::DUR_BITS-1:0] std_dur_q;
	logic                          sel_std;

	assign sel_std = (paddr[sbps_pkg::ADDR_BITS-1:2] == sbps_pkg::REG_STD_DURATION);
	assign pready  = 1'b1;
	assign std_dur = std_dur_q;

	// Write the register on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			std_dur_q <= sbps_pkg::DUR_STD_RESET;
		end else if (psel && penable && pwrite && sel_std) begin
			std_dur_q <= pwdata[sbps_pkg::DUR_BITS-1:0];
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		if (sel_std) begin
			prdata = {{(sbps_pkg::DATA_BITS-sbps_pkg::DUR_BITS){1'b0}}, std_dur_q};
		end
	end

endmodule

>>> rtl/sbps_step.sv
`timescale 1ns / 1ps
// Pattern state and the single-pass step logic: decodes one word, works out
// the pin levels and done flag, and commits the state when told. Depends on sbps_pkg.
module sbps_step (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          commit,
	input  sbps_pkg::item_t               item,
	input  logic [sbps_pkg::DUR_BITS-1:0] std_dur,
	output sbps_pkg::res_t                res
);

	localparam int SB = sbps_pkg::STEP_BITS;

	logic [3:0]    beep_count_q, volume_count_q, last_code_q;
	logic [SB-1:0] beep_end_q, volume_end_q;
	logic [4:0]    pins_q;

	logic [3:0]    bc, vc, lc, code, burst_n;
	logic [SB-1:0] be, ve, s;
	logic [4:0]    pins;
	logic          done, m100, m500, dur_hit;
	logic [sbps_pkg::DUR_BITS-1:0] dur;
	sbps_pkg::act_t act;

	assign s    = item.step;
	assign m100 = sbps_pkg::is_mult100(s);
	assign m500 = sbps_pkg::is_mult500(s);

	// Decode the pattern into an action, a code, a burst count and a duration
	always_comb begin
		act     = sbps_pkg::ACT_BURST;
		burst_n = sbps_pkg::BURST_IDLE;
		dur     = std_dur;
		code    = sbps_pkg::CODE_IDLE;
		if (item.cmd == sbps_pkg::CMD_SIM) begin
			code = {1'b0, item.pattern};
			if (item.pattern == sbps_pkg::PAT_SIM_HOLD) begin
				act = sbps_pkg::ACT_HOLD1;
				dur = sbps_pkg::DUR_HOLD1;
			end else if (item.pattern != sbps_pkg::PAT_IDLE) begin
				burst_n = {1'b0, item.pattern};
			end
		end else begin
			if (item.pattern != sbps_pkg::PAT_IDLE) begin
				code = sbps_pkg::CODE_IND_BASE + {1'b0, item.pattern};
			end
			case (item.pattern)
				sbps_pkg::PAT_HOLD1: begin
					act = sbps_pkg::ACT_HOLD1;
					dur = sbps_pkg::DUR_HOLD1;
				end
				sbps_pkg::PAT_HOLD2: begin
					act = sbps_pkg::ACT_HOLD2;
					dur = sbps_pkg::DUR_HOLD2;
				end
				sbps_pkg::PAT_VOL_UP: begin
					act     = sbps_pkg::ACT_VOL_UP;
					dur     = sbps_pkg::DUR_VOLUME;
					burst_n = sbps_pkg::BURST_VOL;
				end
				sbps_pkg::PAT_VOL_DN: begin
					act     = sbps_pkg::ACT_VOL_DN;
					dur     = sbps_pkg::DUR_VOLUME;
					burst_n = sbps_pkg::BURST_VOL;
				end
				sbps_pkg::PAT_PER_A: begin
					act = sbps_pkg::ACT_PER_A;
					dur = sbps_pkg::DUR_PER_A;
				end
				sbps_pkg::PAT_PER_B: begin
					act = sbps_pkg::ACT_PER_B;
					dur = sbps_pkg::DUR_PER_B;
				end
				sbps_pkg::PAT_UNKNOWN: begin
					act = sbps_pkg::ACT_UNKNOWN;
				end
				default: begin
					act = sbps_pkg::ACT_BURST;
				end
			endcase
		end
	end

	assign dur_hit = (sbps_pkg::CMP_BITS'(s) >= sbps_pkg::CMP_BITS'(dur));

	// Apply the command to a copy of the state
	always_comb begin
		bc   = beep_count_q;
		vc   = volume_count_q;
		be   = beep_end_q;
		ve   = volume_end_q;
		lc   = last_code_q;
		pins = pins_q;
		done = 1'b0;
		case (item.cmd)
			sbps_pkg::CMD_RESET: begin
				bc        = '0;
				vc        = '0;
				ve        = '0;
				pins[2:0] = sbps_pkg::TRACKS_RELEASED;
			end
			sbps_pkg::CMD_SIM, sbps_pkg::CMD_IND: begin
				// volume pulses
				if (act == sbps_pkg::ACT_VOL_UP || act == sbps_pkg::ACT_VOL_DN) begin
					if (m100 && vc < sbps_pkg::VOL_MAX) begin
						vc                   = vc + 4'd1;
						pins[sbps_pkg::PIN_VD] = (act == sbps_pkg::ACT_VOL_UP);
						pins[sbps_pkg::PIN_VU] = (act != sbps_pkg::ACT_VOL_UP);
						ve                   = s + sbps_pkg::VOL_LEN;
					end else if (ve == s) begin
						pins[sbps_pkg::PIN_VD] = 1'b1;
						pins[sbps_pkg::PIN_VU] = 1'b1;
					end
				end
				// beep bursts
				if (act == sbps_pkg::ACT_BURST || act == sbps_pkg::ACT_VOL_UP ||
				    act == sbps_pkg::ACT_VOL_DN) begin
					if (m100 && bc < burst_n) begin
						bc                     = bc + 4'd1;
						pins[sbps_pkg::PIN_T0] = 1'b0;
						be                     = s + sbps_pkg::BEEP_LEN;
					end else if (be == s) begin
						pins[sbps_pkg::PIN_T0] = 1'b1;
					end
				end
				// periodic beeps
				if (act == sbps_pkg::ACT_PER_A || act == sbps_pkg::ACT_PER_B) begin
					if (m500) begin
						pins[sbps_pkg::PIN_T0] = 1'b0;
						be = s + ((act == sbps_pkg::ACT_PER_A) ?
							sbps_pkg::PER_LEN_A : sbps_pkg::PER_LEN_B);
					end else if (be == s) begin
						pins[sbps_pkg::PIN_T0] = 1'b1;
					end
				end
				// held track select
				if (act == sbps_pkg::ACT_HOLD1 || act == sbps_pkg::ACT_HOLD2) begin
					pins[2:0] = sbps_pkg::TRACKS_RELEASED;
					if (act == sbps_pkg::ACT_HOLD1) begin
						pins[sbps_pkg::PIN_T1] = 1'b0;
					end else begin
						pins[sbps_pkg::PIN_T2] = 1'b0;
					end
				end
				// pattern change, end of pattern
				if (act == sbps_pkg::ACT_UNKNOWN) begin
					done = 1'b1;
				end else begin
					if (code != last_code_q && code != sbps_pkg::CODE_IDLE) begin
						pins[2:0] = sbps_pkg::TRACKS_RELEASED;
					end
					if (dur_hit) begin
						bc   = '0;
						vc   = '0;
						pins = sbps_pkg::PINS_RELEASED;
						done = 1'b1;
					end else begin
						lc = code;
					end
				end
			end
			default: begin
				done = 1'b1;
			end
		endcase
	end

	assign res.pins = pins;
	assign res.done = done;

	// Commit the state with the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beep_count_q   <= '0;
			volume_count_q <= '0;
			beep_end_q     <= '0;
			volume_end_q   <= '0;
			last_code_q    <= sbps_pkg::CODE_NONE;
			pins_q         <= sbps_pkg::PINS_RELEASED;
		end else if (commit) begin
			beep_count_q   <= bc;
			volume_count_q <= vc;
			beep_end_q     <= be;
			volume_end_q   <= ve;
			last_code_q    <= lc;
			pins_q         <= pins;
		end
	end

	// Counts never pass their limits
	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		beep_count_q <= sbps_pkg::BURST_VOL && volume_count_q <= sbps_pkg::VOL_MAX)
		else $error("pattern count out of range");

	// Volume up and down are never pressed together
	a_vol_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		pins_q[sbps_pkg::PIN_VD] || pins_q[sbps_pkg::PIN_VU])
		else $error("both volume pins pressed");

	// A reset command clears counts and releases the tracks
	a_reset_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		commit && item.cmd == sbps_pkg::CMD_RESET |=>
		beep_count_q == '0 && volume_count_q == '0 &&
		pins_q[2:0] == sbps_pkg::TRACKS_RELEASED)
		else $error("reset command left state behind");

	// The end of a known pattern releases every pin
	a_end_release: assert property (@(posedge clk) disable iff (!arst_n)
		commit && (item.cmd == sbps_pkg::CMD_SIM || item.cmd == sbps_pkg::CMD_IND) &&
		act != sbps_pkg::ACT_UNKNOWN && dur_hit |=> pins_q == sbps_pkg::PINS_RELEASED)
		else $error("pins not released at pattern end");

	// A running step records its pattern code
	a_code_kept: assert property (@(posedge clk) disable iff (!arst_n)
		commit && !done && item.cmd != sbps_pkg::CMD_RESET |=>
		last_code_q == $past(code))
		else $error("pattern code not recorded");

endmodule

>>> rtl/step_beep_pattern_sequencer_core.sv
`timescale 1ns / 1ps
// Top level of the step beep pattern sequencer: input register, step logic,
// result register and the APB register file. Depends on sbps_pkg, sbps_cfg, sbps_step.

// One input word is taken every cycle unless in_stall is high: the word is captured in
// an input register, the pattern logic runs in one pass on that register and the
// pattern state, and the pins and done flag land in a result register, which presents
// the result. The state is updated as the word moves into the result register, so the
// next word in the following cycle sees it. out_stall reaches in_stall combinationally,
// and only when both registers are full. There is no clearing pass after reset. Write
// standard_duration only while the block is idle.
module step_beep_pattern_sequencer_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       cmd,
	input  logic [2:0]                       pattern,
	input  logic [sbps_pkg::STEP_BITS-1:0]   step,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             track0_level,
	output logic                             track1_level,
	output logic                             track2_level,
	output logic                             vol_down_level,
	output logic                             vol_up_level,
	output logic                             done_res,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sbps_pkg::ADDR_BITS-1:0]   paddr,
	input  logic [sbps_pkg::DATA_BITS-1:0]   pwdata,
	output logic [sbps_pkg::DATA_BITS-1:0]   prdata,
	output logic                             pready
);

	sbps_pkg::item_t item_s1;
	sbps_pkg::res_t  res_c, res_s2;
	logic            valid_s1, valid_s2, advance, fire;
	logic [sbps_pkg::DUR_BITS-1:0] std_dur;

	// Handshake: the result register frees when empty or taken
	assign advance  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	sbps_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.std_dur (std_dur)
	);

	sbps_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.commit  (fire),
		.item    (item_s1),
		.std_dur (std_dur),
		.res     (res_c)
	);

	// Input register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= '{cmd: cmd, pattern: pattern, step: step};
		end
	end

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_c;
		end
	end

	assign out_valid      = valid_s2;
	assign track0_level   = res_s2.pins[sbps_pkg::PIN_T0];
	assign track1_level   = res_s2.pins[sbps_pkg::PIN_T1];
	assign track2_level   = res_s2.pins[sbps_pkg::PIN_T2];
	assign vol_down_level = res_s2.pins[sbps_pkg::PIN_VD];
	assign vol_up_level   = res_s2.pins[sbps_pkg::PIN_VU];
	assign done_res       = res_s2.done;

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for step_beep_pattern_sequencer_core: queue-fed word driver,
// stalling result receiver and a step-by-step pin predictor. Depends on sbps_pkg and the RTL.
module tb;

	localparam int SW          = sbps_pkg::STEP_BITS;
	localparam int AW          = sbps_pkg::ADDR_BITS;
	localparam int DW          = sbps_pkg::DATA_BITS;
	localparam int QUIET_LIMIT = 1000;
	localparam int LONG_HOLD   = 150;
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 112;

	// Pin masks, active low
	localparam logic [4:0] M_T0     = 5'h01;
	localparam logic [4:0] M_T1     = 5'h02;
	localparam logic [4:0] M_T2     = 5'h04;
	localparam logic [4:0] M_VD     = 5'h08;
	localparam logic [4:0] M_VU     = 5'h10;
	localparam logic [4:0] M_TRACKS = 5'h07;
	localparam logic [4:0] M_ALL    = 5'h1F;

	// Timing of the patterns, in steps
	localparam int unsigned BEEP_GAP   = 100;
	localparam int unsigned BEEP_TIME  = 35;
	localparam int unsigned VOL_TIME   = 50;
	localparam int unsigned PER_GAP    = 500;
	localparam int unsigned PER_TIME_A = 175;
	localparam int unsigned PER_TIME_B = 210;
	localparam int unsigned HOLD1_SPAN = 25000;
	localparam int unsigned HOLD2_SPAN = 23500;
	localparam int unsigned VOL_SPAN   = 1000;
	localparam int unsigned PER_A_SPAN = 1175;
	localparam int unsigned PER_B_SPAN = 1210;
	localparam logic [3:0]  VOL_MOST   = 4'd10;
	localparam logic [3:0]  IDLE_BEEPS = 4'd3;
	localparam logic [3:0]  VOL_BEEPS  = 4'd10;

	localparam logic [AW-1:0] STD_DUR_ADDR = {sbps_pkg::REG_STD_DURATION, 2'b00};

	typedef struct packed {
		sbps_pkg::cmd_t cmd;
		logic [2:0]     pattern;
		logic [SW-1:0]  step;
	} step_word_t;

	typedef struct packed {
		logic [4:0] pins;
		logic       done;
	} pin_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	step_word_t drv_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic track0_level, track1_level, track2_level, vol_down_level, vol_up_level, done_res;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [AW-1:0] paddr = '0;
	logic [DW-1:0] pwdata = '0;
	logic [DW-1:0] prdata;
	logic pready;

	step_word_t step_words_q[$];
	pin_word_t  pin_expect_q[$];

	logic in_took = 1'b0;
	logic out_took = 1'b0;
	int   send_wait = 0;
	int   recv_left = 0;
	int   hold_left = 0;
	int   hold_asked = 0;
	int   hold_seen = 0;
	int   idle_level = 2;
	int   quiet_cycles = 0;
	int   mismatches = 0;
	int   words_in = 0;
	int   results_out = 0;
	int   results_done = 0;
	int   phase_words = 0;

	// Predicted state of the sequencer
	logic [15:0]   std_dur;
	logic [3:0]    beeps_given;
	logic [3:0]    vol_pulses;
	logic [SW-1:0] beep_off_step;
	logic [SW-1:0] vol_off_step;
	logic [3:0]    shown_code;
	logic [4:0]    pin_lv;

	step_beep_pattern_sequencer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(drv_word.cmd),
		.pattern(drv_word.pattern),
		.step(drv_word.step),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.track0_level(track0_level),
		.track1_level(track1_level),
		.track2_level(track2_level),
		.vol_down_level(vol_down_level),
		.vol_up_level(vol_up_level),
		.done_res(done_res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic void clear_pattern_state();
		std_dur       = 16'd3000;
		beeps_given   = '0;
		vol_pulses    = '0;
		beep_off_step = '0;
		vol_off_step  = '0;
		shown_code    = sbps_pkg::CODE_NONE;
		pin_lv        = M_ALL;
	endfunction

	// Beep on track 0: counted bursts every 100 steps, or free-running every 500
	function automatic void beep_run(input logic [SW-1:0] s, input int unsigned period,
			input logic [3:0] most, input int unsigned len, input bit counted);
		if (s % period == 0 && (!counted || beeps_given < most)) begin
			if (counted)
				beeps_given = beeps_given + 4'd1;
			pin_lv = pin_lv & ~M_T0;
			beep_off_step = SW'(s + len);
		end else if (beep_off_step == s) begin
			pin_lv = pin_lv | M_T0;
		end
	endfunction

	// Press one volume pin and release the other, at most ten pulses
	function automatic void volume_run(input logic [SW-1:0] s, input bit up);
		if (s % BEEP_GAP == 0 && vol_pulses < VOL_MOST) begin
			vol_pulses = vol_pulses + 4'd1;
			pin_lv = up ? ((pin_lv | M_VD) & ~M_VU) : ((pin_lv | M_VU) & ~M_VD);
			vol_off_step = SW'(s + VOL_TIME);
		end else if (vol_off_step == s) begin
			pin_lv = pin_lv | M_VD | M_VU;
		end
	endfunction

	function automatic void hold_track(input logic [4:0] which);
		pin_lv = (pin_lv | M_TRACKS) & ~which;
	endfunction

	// Step count at which a pattern ends
	function automatic int unsigned pattern_span(input sbps_pkg::cmd_t c,
			input logic [2:0] p);
		if (c == sbps_pkg::CMD_SIM)
			return (p == sbps_pkg::PAT_SIM_HOLD) ? HOLD1_SPAN : int'(std_dur);
		case (p)
			sbps_pkg::PAT_HOLD1: return HOLD1_SPAN;
			sbps_pkg::PAT_HOLD2: return HOLD2_SPAN;
			sbps_pkg::PAT_VOL_UP, sbps_pkg::PAT_VOL_DN: return VOL_SPAN;
			sbps_pkg::PAT_PER_A: return PER_A_SPAN;
			sbps_pkg::PAT_PER_B: return PER_B_SPAN;
			default: return int'(std_dur);
		endcase
	endfunction

	// Advance the predicted sequencer by one step word and give the pins it shows
	function automatic pin_word_t predict_pins(input step_word_t w);
		pin_word_t r;
		logic [3:0] code;
		int unsigned span;
		logic done;
		done = 1'b0;
		code = sbps_pkg::CODE_IDLE;
		span = pattern_span(w.cmd, w.pattern);
		case (w.cmd)
			sbps_pkg::CMD_RESET: begin
				beeps_given  = '0;
				vol_pulses   = '0;
				vol_off_step = '0;
				pin_lv = pin_lv | M_TRACKS;
			end
			sbps_pkg::CMD_UNDEF: done = 1'b1;
			default: begin
				if (w.cmd == sbps_pkg::CMD_IND && w.pattern == sbps_pkg::PAT_UNKNOWN) begin
					done = 1'b1;
				end else begin
					if (w.cmd == sbps_pkg::CMD_SIM) begin
						code = {1'b0, w.pattern};
						if (w.pattern == sbps_pkg::PAT_SIM_HOLD)
							hold_track(M_T1);
						else
							beep_run(w.step, BEEP_GAP,
								(w.pattern == sbps_pkg::PAT_IDLE) ?
								IDLE_BEEPS : {1'b0, w.pattern},
								BEEP_TIME, 1'b1);
					end else begin
						code = (w.pattern == sbps_pkg::PAT_IDLE) ? sbps_pkg::CODE_IDLE :
							sbps_pkg::CODE_IND_BASE + w.pattern;
						case (w.pattern)
							sbps_pkg::PAT_IDLE:
								beep_run(w.step, BEEP_GAP, IDLE_BEEPS, BEEP_TIME, 1'b1);
							sbps_pkg::PAT_HOLD1: hold_track(M_T1);
							sbps_pkg::PAT_HOLD2: hold_track(M_T2);
							sbps_pkg::PAT_VOL_UP, sbps_pkg::PAT_VOL_DN: begin
								volume_run(w.step, w.pattern == sbps_pkg::PAT_VOL_UP);
								beep_run(w.step, BEEP_GAP, VOL_BEEPS, BEEP_TIME, 1'b1);
							end
							sbps_pkg::PAT_PER_A:
								beep_run(w.step, PER_GAP, '0, PER_TIME_A, 1'b0);
							sbps_pkg::PAT_PER_B:
								beep_run(w.step, PER_GAP, '0, PER_TIME_B, 1'b0);
							default: ;
						endcase
					end
					// a new pattern lets go of every track after its own action
					if (code != shown_code && code != sbps_pkg::CODE_IDLE)
						pin_lv = pin_lv | M_TRACKS;
					if (w.step >= span) begin
						beeps_given = '0;
						vol_pulses  = '0;
						pin_lv      = M_ALL;
						done        = 1'b1;
					end else begin
						shown_code = code;
					end
				end
			end
		endcase
		r.pins = pin_lv;
		r.done = done;
		return r;
	endfunction

	function automatic int draw_wait();
		case (idle_level)
			0: return 0;
			1: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 19)) : 0;
			default: return $urandom_range(0, 19);
		endcase
	endfunction

	function automatic void compare_level(input string name, input logic want, input logic got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0b, got %0b", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Present queued words, holding each until it is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_took) begin
			if (send_wait > 0) begin
				in_valid <= 1'b0;
				send_wait <= send_wait - 1;
			end else if (step_words_q.size() > 0) begin
				drv_word <= step_words_q.pop_front();
				in_valid <= 1'b1;
				send_wait <= draw_wait();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall results at random, and hold off for a long stretch on request
	always @(negedge clk) begin
		if (hold_seen != hold_asked) begin
			hold_seen = hold_asked;
			hold_left = LONG_HOLD;
		end
		if (out_took)
			recv_left = draw_wait();
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (recv_left > 0 && out_valid) begin
			recv_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Predict on every accepted word, check every accepted result
	always @(posedge clk) begin : word_monitor
		pin_word_t got;
		pin_word_t want;
		in_took  <= in_valid && !in_stall;
		out_took <= out_valid && !out_stall;
		if (in_valid && !in_stall) begin
			pin_expect_q.push_back(predict_pins(drv_word));
			words_in++;
		end
		if (out_valid && !out_stall) begin
			got.pins = {vol_up_level, vol_down_level, track2_level, track1_level, track0_level};
			got.done = done_res;
			results_out++;
			if (got.done === 1'b1)
				results_done++;
			if (pin_expect_q.size() == 0) begin
				$display("%0t: result with nothing expected, pins %b done %b",
					$time, got.pins, got.done);
				mismatches++;
			end else begin
				want = pin_expect_q.pop_front();
				compare_level("track0_level", want.pins[0], got.pins[0]);
				compare_level("track1_level", want.pins[1], got.pins[1]);
				compare_level("track2_level", want.pins[2], got.pins[2]);
				compare_level("vol_down_level", want.pins[3], got.pins[3]);
				compare_level("vol_up_level", want.pins[4], got.pins[4]);
				compare_level("done_res", want.done, got.done);
			end
		end
	end

	// Drop the run if no handshake happens for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no word moved for %0d cycles, %0d results outstanding",
				$time, quiet_cycles, pin_expect_q.size());
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic queue_word(input sbps_pkg::cmd_t c, input logic [2:0] p,
			input int unsigned s);
		step_word_t w;
		w.cmd = c;
		w.pattern = p;
		w.step = SW'(s);
		step_words_q.push_back(w);
		phase_words++;
	endtask

	// Wait until the sender is empty and every expected result has come back
	task automatic wait_idle();
		@(posedge clk);
		while (step_words_q.size() != 0 || in_valid || pin_expect_q.size() != 0)
			@(posedge clk);
	endtask

	// Write standard_duration, then read it back in the same transfer sequence
	task automatic set_std_duration(input logic [15:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= STD_DUR_ADDR;
		pwdata <= DW'(v);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		std_dur = v;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[15:0] !== v) begin
			$display("%0t: standard_duration read mismatch, expected %0d, got %0d",
				$time, v, prdata[15:0]);
			mismatches++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// One pattern walked through its key steps, or a stray word
	task automatic queue_pattern_run();
		sbps_pkg::cmd_t c;
		logic [2:0] p;
		int unsigned s;
		int unsigned span;
		int unsigned len;
		if ($urandom_range(0, 6) == 0) begin
			case ($urandom_range(0, 5))
				0: s = 0;
				1: s = 65535;
				2: s = 65500;
				3: s = BEEP_GAP * $urandom_range(0, 655);
				default: s = $urandom_range(0, 65535);
			endcase
			queue_word(sbps_pkg::cmd_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), s);
			return;
		end
		c = ($urandom_range(0, 1) == 1) ? sbps_pkg::CMD_IND : sbps_pkg::CMD_SIM;
		p = (c == sbps_pkg::CMD_IND) ? 3'($urandom_range(0, 6)) : 3'($urandom_range(0, 7));
		span = pattern_span(c, p);
		s = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2000) : 0;
		len = $urandom_range(3, 40);
		repeat (len) begin
			if (s >= span || s > 65535)
				break;
			queue_word(c, p, s);
			// land on pulse starts and ends most of the time
			case ($urandom_range(0, 7))
				0: s += BEEP_GAP - s % BEEP_GAP;
				1: s += PER_GAP - s % PER_GAP;
				2: s += BEEP_TIME;
				3: s += VOL_TIME;
				4: s += PER_TIME_A;
				5: s += PER_TIME_B;
				6: s += 1;
				default: s += $urandom_range(1, 150);
			endcase
		end
		case ($urandom_range(0, 5))
			0: ;
			1: begin
				if (span > 0)
					queue_word(c, p, span - 1);
				queue_word(c, p, span);
			end
			default: begin
				s = span + $urandom_range(0, 200);
				queue_word(c, p, (s > 65535) ? 65535 : s);
			end
		endcase
	endtask

	initial begin : stimulus
		logic [15:0] dur_list [PHASES];
		int ph;
		dur_list = '{16'd0, 16'hFFFF, 16'd650, 16'd1, 16'd1100, 16'd3000, 16'd0, 16'd350};
		dur_list[6] = 16'($urandom_range(0, 65535));
		clear_pattern_state();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Directed words at the reset duration
		idle_level = 2;
		queue_word(sbps_pkg::CMD_SIM, sbps_pkg::PAT_IDLE, 0);
		queue_word(sbps_pkg::CMD_SIM, sbps_pkg::PAT_IDLE, 35);
		queue_word(sbps_pkg::CMD_SIM, sbps_pkg::PAT_IDLE, 100);
		queue_word(sbps_pkg::CMD_SIM, 3'd1, 200);
		queue_word(sbps_pkg::CMD_SIM, 3'd6, 300);
		queue_word(sbps_pkg::CMD_SIM, sbps_pkg::PAT_SIM_HOLD, 100);
		queue_word(sbps_pkg::CMD_SIM, sbps_pkg::PAT_SIM_HOLD, 101);
		queue_word(sbps_pkg::CMD_SIM, sbps_pkg::PAT_SIM_HOLD, HOLD1_SPAN);
		queue_word(sbps_pkg::CMD_IND, sbps_pkg::PAT_HOLD1, 5);
		queue_word(sbps_pkg::CMD_IND, sbps_pkg::PAT_HOLD1, 6);
		queue_word(sbps_pkg::CMD_IND, sbps_pkg::PAT_HOLD2, HOLD2_SPAN - 1);
		queue_word(sbps_pkg::CMD_IND, sbps_pkg::PAT_HOLD2, HOLD2_SPAN);
		queue_word(sbps_pkg::CMD_IND, sbps_pkg::PAT_VOL_UP, 0);
		queue_word(sbps_pkg::CMD_IND, sbps_pkg::PAT_VOL_UP, 50);
		queue_word(sbps_pkg::CMD_IND, sbps_pkg::PAT_VOL_DN, 100);
		queue_word(sbps_pkg::CMD_RESET, sbps_pkg::PAT_IDLE, 12);
		queue_word(sbps_pkg::CMD_IND, sbps_pkg::PAT_VOL_DN, VOL_SPAN);
		queue_word(sbps_pkg::CMD_IND, sbps_pkg::PAT_PER_A, 0);
		queue_word(sbps_pkg::CMD_IND, sbps_pkg::PAT_PER_A, 500);
		queue_word(sbps_pkg::CMD_IND, sbps_pkg::PAT_PER_A, 675);
		// periodic beep end wraps past the top of the step range
		queue_word(sbps_pkg::CMD_IND, sbps_pkg::PAT_PER_B, 65500);
		queue_word(sbps_pkg::CMD_SIM, sbps_pkg::PAT_IDLE, 174);
		queue_word(sbps_pkg::CMD_IND, sbps_pkg::PAT_UNKNOWN, 3);
		queue_word(sbps_pkg::CMD_UNDEF, sbps_pkg::PAT_UNKNOWN, 65535);
		queue_word(sbps_pkg::CMD_SIM, sbps_pkg::PAT_IDLE, 65535);
		wait_idle();

		// Random phases, each at its own duration and idling level
		for (ph = 0; ph < PHASES; ph++) begin
			set_std_duration(dur_list[ph]);
			idle_level = ph % 3;
			phase_words = 0;
			while (phase_words < PHASE_WORDS)
				queue_pattern_run();
			if (ph == 3)
				hold_asked++;
			wait_idle();
		end

		repeat (10) @(posedge clk);
		if (pin_expect_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, pin_expect_q.size());
			mismatches++;
		end
		$display("Run covered %0d step words and %0d results over %0d duration settings,",
			words_in, results_out, PHASES + 1);
		$display("with %0d results flagged done and %0d mismatches.", results_done, mismatches);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
